@@ rtl/core/ssc_pkg.sv @@
// ssc_pkg: shared types and codes for the sorted set check merge block
// request/result words, queued command word, queue status, back-end states
// no dependencies
package ssc_pkg;

	// request codes as they arrive on the port
	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_CAND   = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [23:0] object_id;
		logic [7:0]  read_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        to_check;
		logic [23:0] id_out;
		logic [6:0]  check_count;
		logic [7:0]  checked_count;
		logic        dropped;
	} rsp_t;

	// classified operation; encoding matches the request code it answers
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_CAND   = 2'd1,
		OP_FINISH = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [23:0] id;
		logic [7:0]  idx;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CAND_CMP,
		ST_FIN_LOOP,
		ST_FIN_CP,
		ST_READ_OUT
	} back_state_t;

endpackage

@@ rtl/core/ssc_front.sv @@
// ssc_front: request acceptance and classification
// decodes the request code, masks the id to ID_BITS, pushes into the queue
// depends on ssc_pkg
module ssc_front
	import ssc_pkg::*;
#(
	parameter int ID_BITS = 24
) (
	input  logic      start,
	input  req_t      request,
	input  q_status_t status,
	output logic      busy,
	output logic      push,
	output cmd_t      cmd
);

	localparam int XW = (ID_BITS > 24) ? ID_BITS : 24;
	localparam logic [XW-1:0] IdMask = (XW'(1) << ID_BITS) - XW'(1);

	logic [XW-1:0] id_wide;

	assign busy    = status.full;
	assign push    = start && !status.full;
	assign id_wide = XW'(request.object_id) & IdMask;

	always_comb begin
		cmd.id  = id_wide[23:0];
		cmd.idx = request.read_index;
		unique case (request.req_type)
			REQ_CLEAR:  cmd.op = OP_CLEAR;
			REQ_CAND:   cmd.op = OP_CAND;
			REQ_FINISH: cmd.op = OP_FINISH;
			REQ_READ:   cmd.op = OP_READ;
			default:    cmd.op = OP_READ;
		endcase
	end

endmodule

@@ rtl/core/ssc_queue.sv @@
// ssc_queue: short command queue between front and back
// two entries, push and pop may happen in the same cycle
// depends on ssc_pkg
module ssc_queue
	import ssc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t status
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CNW   = $clog2(DEPTH + 1);

	cmd_t           mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CNW-1:0] count_q;
	logic           do_push;
	logic           do_pop;

	assign status.full  = (count_q == CNW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNW'(1);
				2'b01:   count_q <= count_q - CNW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/ssc_back.sv @@
// ssc_back: merge engine with the two id banks
// copies checked ids into the merged bank, judges candidates, swaps banks
// depends on ssc_pkg
module ssc_back
	import ssc_pkg::*;
#(
	parameter int MAX_SET     = 127,
	parameter int MAX_CHECKED = 255,
	parameter int ID_BITS     = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  q_status_t status,
	output logic      pop,
	output logic      done,
	output rsp_t      result
);

	localparam int CW   = $clog2(MAX_CHECKED + 1);
	localparam int IW   = $clog2(MAX_CHECKED);
	localparam int NW   = $clog2(MAX_SET + 1);
	localparam int IDXW = (CW > 8) ? CW : 8;
	localparam int XW   = (ID_BITS > 24) ? ID_BITS : 24;
	localparam int KW   = (NW > 7) ? NW : 7;

	logic [ID_BITS-1:0] bank_a [MAX_CHECKED];
	logic [ID_BITS-1:0] bank_b [MAX_CHECKED];
	logic [ID_BITS-1:0] rd_a_q;
	logic [ID_BITS-1:0] rd_b_q;
	logic [ID_BITS-1:0] rdata;

	back_state_t    state_q, state_d;
	cmd_t           cmd_q;
	logic [CW-1:0]  checked_size_q, checked_size_d;
	logic [CW-1:0]  merged_size_q, merged_size_d;
	logic [CW-1:0]  old_ptr_q, old_ptr_d;
	logic [NW-1:0]  new_cand_q, new_cand_d;
	logic           bank_sel_q, bank_sel_d;
	logic           done_q;
	rsp_t           rsp_q, rsp_d;

	logic               re, we;
	logic [IW-1:0]      raddr, waddr;
	logic [ID_BITS-1:0] wdata;

	logic               app_en;
	logic [ID_BITS-1:0] app_data;
	logic               decide_en, decide_present;
	logic               emit_en, emit_chk, emit_drop;
	logic [ID_BITS-1:0] emit_id;
	logic [NW-1:0]      emit_cnt;

	logic [XW-1:0]      cand_wide;
	logic [ID_BITS-1:0] cand_id;
	logic [IDXW-1:0]    idx_ext, size_ext, cnt8_ext;
	logic [XW-1:0]      out_id_wide;
	logic [KW-1:0]      out_cnt_wide;
	logic               old_left, read_hit;

	assign cand_wide = XW'(cmd_q.id);
	assign cand_id   = cand_wide[ID_BITS-1:0];
	assign idx_ext   = IDXW'(cmd_q.idx);
	assign size_ext  = IDXW'(checked_size_q);
	assign read_hit  = idx_ext < size_ext;
	assign old_left  = old_ptr_q < checked_size_q;
	assign rdata     = bank_sel_q ? rd_b_q : rd_a_q;

	// bank_sel 0: bank a holds the checked set, bank b is being merged into
	always_ff @(posedge clk) begin
		if (we && bank_sel_q) begin
			bank_a[waddr] <= wdata;
		end
		if (we && !bank_sel_q) begin
			bank_b[waddr] <= wdata;
		end
		if (re) begin
			rd_a_q <= bank_a[raddr];
			rd_b_q <= bank_b[raddr];
		end
	end

	always_comb begin
		state_d        = state_q;
		checked_size_d = checked_size_q;
		merged_size_d  = merged_size_q;
		old_ptr_d      = old_ptr_q;
		new_cand_d     = new_cand_q;
		bank_sel_d     = bank_sel_q;
		pop            = 1'b0;
		re             = 1'b0;
		raddr          = old_ptr_q[IW-1:0];
		app_en         = 1'b0;
		app_data       = rdata;
		decide_en      = 1'b0;
		decide_present = 1'b0;
		emit_en        = 1'b0;
		emit_chk       = 1'b0;
		emit_drop      = 1'b0;
		emit_id        = '0;
		emit_cnt       = new_cand_q;

		unique case (state_q)
			ST_IDLE: begin
				if (!status.empty) begin
					pop     = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (cmd_q.op)
					OP_CLEAR: begin
						checked_size_d = '0;
						merged_size_d  = '0;
						old_ptr_d      = '0;
						new_cand_d     = '0;
						emit_en        = 1'b1;
						emit_cnt       = '0;
						state_d        = ST_IDLE;
					end
					OP_CAND: begin
						if (old_left) begin
							re      = 1'b1;
							state_d = ST_CAND_CMP;
						end else begin
							decide_en = 1'b1;
							state_d   = ST_IDLE;
						end
					end
					OP_FINISH: begin
						if (new_cand_q != '0) begin
							state_d = ST_FIN_LOOP;
						end else begin
							merged_size_d = '0;
							old_ptr_d     = '0;
							emit_en       = 1'b1;
							state_d       = ST_IDLE;
						end
					end
					OP_READ: begin
						if (read_hit) begin
							re      = 1'b1;
							raddr   = idx_ext[IW-1:0];
							state_d = ST_READ_OUT;
						end else begin
							emit_en = 1'b1;
							state_d = ST_IDLE;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_CAND_CMP: begin
				if (rdata < cand_id) begin
					app_en    = 1'b1;
					old_ptr_d = old_ptr_q + CW'(1);
					state_d   = ST_EXEC;
				end else begin
					decide_en      = 1'b1;
					decide_present = (rdata == cand_id);
					state_d        = ST_IDLE;
				end
			end
			ST_FIN_LOOP: begin
				if (old_left) begin
					re      = 1'b1;
					state_d = ST_FIN_CP;
				end else begin
					checked_size_d = merged_size_q;
					bank_sel_d     = !bank_sel_q;
					merged_size_d  = '0;
					old_ptr_d      = '0;
					new_cand_d     = '0;
					emit_en        = 1'b1;
					emit_cnt       = new_cand_q;
					state_d        = ST_IDLE;
				end
			end
			ST_FIN_CP: begin
				app_en    = 1'b1;
				old_ptr_d = old_ptr_q + CW'(1);
				state_d   = ST_FIN_LOOP;
			end
			ST_READ_OUT: begin
				emit_en = 1'b1;
				emit_id = rdata;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase

		// verdict on a candidate once all lower checked ids are copied
		if (decide_en) begin
			emit_en = 1'b1;
			emit_id = cand_id;
			if (decide_present) begin
				emit_chk = 1'b0;
			end else if (new_cand_q >= NW'(MAX_SET)) begin
				emit_drop = 1'b1;
			end else begin
				app_en     = 1'b1;
				app_data   = cand_id;
				new_cand_d = new_cand_q + NW'(1);
				emit_chk   = 1'b1;
			end
			emit_cnt = new_cand_d;
		end

		// appends past capacity are silently lost (truncation)
		we    = app_en && (merged_size_q < CW'(MAX_CHECKED));
		waddr = merged_size_q[IW-1:0];
		wdata = app_data;
		if (we) begin
			merged_size_d = merged_size_q + CW'(1);
		end

		out_id_wide  = XW'(emit_id);
		out_cnt_wide = KW'(emit_cnt);
		cnt8_ext     = IDXW'(checked_size_d);
		rsp_d.kind          = cmd_q.op;
		rsp_d.to_check      = emit_chk;
		rsp_d.id_out        = out_id_wide[23:0];
		rsp_d.check_count   = out_cnt_wide[6:0];
		rsp_d.checked_count = cnt8_ext[7:0];
		rsp_d.dropped       = emit_drop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			checked_size_q <= '0;
			merged_size_q  <= '0;
			old_ptr_q      <= '0;
			new_cand_q     <= '0;
			bank_sel_q     <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			state_q        <= state_d;
			checked_size_q <= checked_size_d;
			merged_size_q  <= merged_size_d;
			old_ptr_q      <= old_ptr_d;
			new_cand_q     <= new_cand_d;
			bank_sel_q     <= bank_sel_d;
			done_q         <= emit_en;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (emit_en) begin
			rsp_q <= rsp_d;
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

	a_ptr_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		old_ptr_q <= checked_size_q)
		else $error("old pointer ran past the checked set");

	a_merge_cap: assert property (@(posedge clk) disable iff (!arst_n)
		merged_size_q <= CW'(MAX_CHECKED) && checked_size_q <= CW'(MAX_CHECKED))
		else $error("store size beyond capacity");

	a_cand_cap: assert property (@(posedge clk) disable iff (!arst_n)
		new_cand_q <= NW'(MAX_SET))
		else $error("candidate count beyond set limit");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result strobe while still working");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_EXEC)
		else $error("popped command not executed");

endmodule

@@ rtl/core/sorted_set_check_merge.sv @@
// sorted_set_check_merge: top level of the sorted set check merge block
// front (ssc_front), command queue (ssc_queue), merge engine (ssc_back)
// depends on ssc_pkg
//
// usage
//  - a request word is taken at a rising edge with start high and busy low;
//    busy is high only while the two-entry command queue is full
//  - every request gives exactly one result word: done is high for one cycle
//    with the word on result; the receiver cannot hold it off
//  - candidates (request 1) of one set come in ascending id order; finish
//    (request 2) closes the set and, if new ids came, swaps the checked and merged banks
//  - a candidate first copies every checked id below it into the merged bank,
//    then compares against the next checked id if one is left; a finish with
//    new ids copies the remaining checked ids before the swap
//  - throughput is set by the copy loop, which reads and copies one id before
//    the next on the single bank read port; the engine works one request at a
//    time while the queue takes up to two more
//  - reset clears counts, pointers, bank select and queue; the id banks
//    hold no reset value and are never read below an unwritten entry
module sorted_set_check_merge
	import ssc_pkg::*;
#(
	parameter int MAX_SET     = 127,
	parameter int MAX_CHECKED = 255,
	parameter int ID_BITS     = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	// front to queue
	logic      push;
	cmd_t      push_cmd;
	// queue to back
	cmd_t      head;
	q_status_t status;
	logic      pop;

	ssc_front #(
		.ID_BITS(ID_BITS)
	) u_front (
		.start  (start),
		.request(request),
		.status (status),
		.busy   (busy),
		.push   (push),
		.cmd    (push_cmd)
	);

	ssc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.status  (status)
	);

	ssc_back #(
		.MAX_SET    (MAX_SET),
		.MAX_CHECKED(MAX_CHECKED),
		.ID_BITS    (ID_BITS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.status(status),
		.pop   (pop),
		.done  (done),
		.result(result)
	);

endmodule

@@ verif/checked_set_sb_pkg.sv @@
// checked_set_sb_pkg: scoreboard for the sorted set check merge testbench
// keeps its own copy of the checked/merged banks and predicts each result word
// depends on ssc_pkg
package checked_set_sb_pkg;
	import ssc_pkg::*;

	localparam int MAX_SET      = 127;
	localparam int MAX_CHECKED  = 255;
	localparam int REPORT_LIMIT = 10;

	class checked_set_scoreboard;
		logic [23:0] bank [2][MAX_CHECKED];
		int unsigned checked_size;
		int unsigned merged_size;
		int unsigned old_ptr;
		int unsigned new_count;
		bit          bank_sel;
		rsp_t        expected_words[$];
		int unsigned mismatches;
		int unsigned words_seen;

		function new();
			checked_size = 0;
			merged_size  = 0;
			old_ptr      = 0;
			new_count    = 0;
			bank_sel     = 1'b0;
			mismatches   = 0;
			words_seen   = 0;
		endfunction

		// ids past the merged bank capacity are lost (truncation)
		function void merged_append(logic [23:0] id);
			if (merged_size < MAX_CHECKED) begin
				bank[bank_sel ^ 1'b1][merged_size] = id;
				merged_size++;
			end
		endfunction

		function rsp_t answer_for(req_t r);
			rsp_t        a;
			int unsigned closed;
			bit          present;
			a = '0;
			a.kind = r.req_type;
			case (r.req_type)
				REQ_CLEAR: begin
					checked_size = 0;
					merged_size  = 0;
					old_ptr      = 0;
					new_count    = 0;
				end
				REQ_CAND: begin
					while (old_ptr < checked_size && bank[bank_sel][old_ptr] < r.object_id) begin
						merged_append(bank[bank_sel][old_ptr]);
						old_ptr++;
					end
					present = old_ptr < checked_size && bank[bank_sel][old_ptr] == r.object_id;
					a.id_out = r.object_id;
					if (!present) begin
						if (new_count >= MAX_SET) begin
							a.dropped = 1'b1;
						end else begin
							merged_append(r.object_id);
							new_count++;
							a.to_check = 1'b1;
						end
					end
				end
				REQ_FINISH: begin
					closed = new_count;
					if (closed != 0) begin
						while (old_ptr < checked_size) begin
							merged_append(bank[bank_sel][old_ptr]);
							old_ptr++;
						end
						checked_size = merged_size;
						bank_sel ^= 1'b1;
					end
					merged_size = 0;
					old_ptr     = 0;
					new_count   = 0;
					a.check_count   = 7'(closed);
					a.checked_count = 8'(checked_size);
					return a;
				end
				REQ_READ: begin
					if (r.read_index < checked_size)
						a.id_out = bank[bank_sel][r.read_index];
				end
			endcase
			a.check_count   = 7'(new_count);
			a.checked_count = 8'(checked_size);
			return a;
		endfunction

		function void note_request(req_t r);
			expected_words.push_back(answer_for(r));
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			bit   bad;
			words_seen++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("word %0d: unexpected result kind %0d id %06h",
						words_seen, got.kind, got.id_out);
				return;
			end
			want = expected_words.pop_front();
			bad = got.kind !== want.kind || got.to_check !== want.to_check ||
				got.id_out !== want.id_out || got.check_count !== want.check_count ||
				got.checked_count !== want.checked_count || got.dropped !== want.dropped;
			if (bad) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("word %0d: expected kind %0d chk %0d id %06h cnt %0d size %0d drop %0d",
						words_seen, want.kind, want.to_check, want.id_out,
						want.check_count, want.checked_count, want.dropped);
					$display("word %0d:      got kind %0d chk %0d id %06h cnt %0d size %0d drop %0d",
						words_seen, got.kind, got.to_check, got.id_out,
						got.check_count, got.checked_count, got.dropped);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_words.size();
		endfunction

		// index of the first checked id at or above v, -1 if none
		function int first_checked_from(int unsigned v);
			for (int i = 0; i < checked_size; i++)
				if (bank[bank_sel][i] >= v)
					return i;
			return -1;
		endfunction
	endclass

endpackage

@@ verif/tb_sorted_set_check_merge.sv @@
// tb_sorted_set_check_merge: self-checking testbench for sorted_set_check_merge
// directed then random request words, every result word checked in order
// depends on ssc_pkg, checked_set_sb_pkg and the block's rtl
module tb_sorted_set_check_merge;
	timeunit 1ns;
	timeprecision 1ps;

	import ssc_pkg::*;
	import checked_set_sb_pkg::*;

	localparam int ITEM_TARGET  = 950;
	// slowest item is a finish copying a full bank; ample margin
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int DRAIN_CYCLES = 32;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic done;
	rsp_t result;

	checked_set_scoreboard sb;
	int unsigned           words_sent;
	int unsigned           idle_pct;
	longint unsigned       cycles;

	sorted_set_check_merge dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always #2 clk = ~clk;

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// a result word is only valid for the one cycle done is high
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	function automatic req_t word_of(logic [1:0] k, logic [23:0] id, logic [7:0] idx);
		req_t r;
		r.req_type   = k;
		r.object_id  = id;
		r.read_index = idx;
		return r;
	endfunction

	// random gap first, then hold the word until the block takes it
	// start is left high after acceptance so back-to-back words need no toggle
	task automatic send_word(input req_t r);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		words_sent++;
	endtask

	// mostly in-range reads, some misses past the end of the set
	task automatic send_read();
		logic [7:0] idx;
		if (sb.checked_size > 0 && $urandom_range(99) < 70)
			idx = 8'($urandom_range(0, sb.checked_size - 1));
		else
			idx = 8'($urandom_range(0, 254));
		send_word(word_of(REQ_READ, 24'($urandom), idx));
	endtask

	// one well-formed candidate set: ascending ids, a share of them taken
	// from the checked set (duplicates), closed by a finish
	task automatic send_candidate_set(int unsigned count, int unsigned step_max,
			int unsigned reuse_pct);
		int unsigned cur;
		int          pos;
		cur = $urandom_range(0, step_max);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 5)
				send_read();
			pos = sb.first_checked_from(cur + 1);
			if (pos >= 0 && $urandom_range(99) < reuse_pct) begin
				// skip a few checked ids so they get copied over by the merge
				pos += $urandom_range(0, 2);
				if (pos >= int'(sb.checked_size))
					pos = sb.checked_size - 1;
				cur = sb.bank[sb.bank_sel][pos];
			end else begin
				cur = cur + $urandom_range(1, step_max);
			end
			if (cur > 32'h00FF_FFFF)
				break;
			send_word(word_of(REQ_CAND, cur[23:0], 8'($urandom_range(0, 254))));
		end
		send_word(word_of(REQ_FINISH, 24'($urandom), 8'($urandom_range(0, 254))));
	endtask

	initial begin
		int unsigned act;
		int unsigned step_max;
		sb         = new();
		words_sent = 0;
		idle_pct   = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		request    = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty set, id extremes, duplicates, misses, out of order
		send_word(word_of(REQ_CLEAR, 24'h0, 8'h0));
		send_word(word_of(REQ_READ, 24'h0, 8'd0));          // read of empty set
		send_word(word_of(REQ_FINISH, 24'h0, 8'h0));        // finish with nothing new
		send_word(word_of(REQ_CAND, 24'h000000, 8'h0));
		send_word(word_of(REQ_CAND, 24'h000005, 8'h0));
		send_word(word_of(REQ_CAND, 24'hFFFFFF, 8'd254));
		send_word(word_of(REQ_FINISH, 24'hFFFFFF, 8'd254));
		send_word(word_of(REQ_READ, 24'h0, 8'd0));
		send_word(word_of(REQ_READ, 24'hFFFFFF, 8'd2));
		send_word(word_of(REQ_READ, 24'h0, 8'd254));        // index past the set
		send_word(word_of(REQ_CAND, 24'h000000, 8'h55));    // duplicate of the lowest id
		send_word(word_of(REQ_CAND, 24'h000003, 8'h0));
		send_word(word_of(REQ_CAND, 24'h000005, 8'h0));     // duplicate in the middle
		send_word(word_of(REQ_CAND, 24'h800000, 8'hAA));
		send_word(word_of(REQ_FINISH, 24'h0, 8'h0));
		send_word(word_of(REQ_READ, 24'h0, 8'd4));
		send_word(word_of(REQ_CAND, 24'h000009, 8'h0));
		send_word(word_of(REQ_CAND, 24'h000004, 8'h0));     // out of order
		send_word(word_of(REQ_FINISH, 24'h0, 8'h0));
		send_word(word_of(REQ_READ, 24'h0, 8'd3));
		send_word(word_of(REQ_CLEAR, 24'hFFFFFF, 8'd254));
		send_word(word_of(REQ_READ, 24'h0, 8'd0));
		send_word(word_of(REQ_CAND, 24'hABCDEF, 8'hAA));
		send_word(word_of(REQ_FINISH, 24'h0, 8'h0));

		// random: mostly candidate sets, some reads, clears and noise
		while (words_sent < ITEM_TARGET) begin
			// switch between no gaps, heavy gaps and light gaps now and then
			if ($urandom_range(99) < 25) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 78;
					default: idle_pct = 35;
				endcase
			end
			act = $urandom_range(99);
			if (act < 3) begin
				send_word(word_of(REQ_CLEAR, 24'($urandom), 8'($urandom_range(0, 254))));
			end else if (act < 10) begin
				repeat ($urandom_range(1, 4)) send_read();
			end else if (act < 18) begin
				// noise: any request with any fields, unsorted ids included
				repeat ($urandom_range(1, 3))
					send_word(word_of(2'($urandom_range(0, 3)), 24'($urandom),
						8'($urandom_range(0, 254))));
			end else if (act < 24) begin
				// big set: can fill the new-id limit and push the bank to truncation
				send_candidate_set($urandom_range(128, 150), 1 << 16, 5);
			end else begin
				case ($urandom_range(0, 3))
					0: step_max = 4;
					1: step_max = 64;
					2: step_max = 4096;
					default: step_max = 1 << 18;
				endcase
				send_candidate_set($urandom_range(1, 12), step_max, 35);
			end
		end
		start <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		// catch any stray result word
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
